[sv/cfir_pkg.sv]
package cfir_pkg;

    localparam int MAX_TAPS      = 256;
    localparam int SAMPLE_BITS   = 16;
    localparam int TAP_REG_BITS  = 9;
    localparam int COEF_IDX_BITS = 8;
    localparam int OUT_BITS      = 40;
    localparam int PROD_BITS     = 2 * SAMPLE_BITS;
    localparam int IDX_W         = $clog2(MAX_TAPS);
    localparam int CNT_W         = IDX_W + 1;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_COEF  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] i;
        logic signed [SAMPLE_BITS-1:0] q;
    } t_smp;

    typedef struct packed {
        logic             shift;
        logic             clear;
        logic             write;
        logic [IDX_W-1:0] wr_pos;
        logic [IDX_W-1:0] last;
        t_smp             smp;
    } t_cell_ctl;

    typedef struct packed {
        logic                          issue;
        logic                          clr_acc;
        logic [IDX_W-1:0]              rd_addr;
        logic                          coef_we;
        logic [IDX_W-1:0]              coef_wa;
        logic signed [SAMPLE_BITS-1:0] coef_wd;
    } t_mac_ctl;

endpackage

[sv/cfir_in_if.sv]
interface cfir_in_if import cfir_pkg::*;;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      operation;
    logic signed [SAMPLE_BITS-1:0]   sample_i;
    logic signed [SAMPLE_BITS-1:0]   sample_q;
    logic [COEF_IDX_BITS-1:0]        coef_index;
    logic signed [SAMPLE_BITS-1:0]   coef_value;

    modport source (output valid, operation, sample_i, sample_q, coef_index, coef_value,
                    input ready);
    modport sink (input valid, operation, sample_i, sample_q, coef_index, coef_value,
                  output ready);
endinterface

[sv/cfir_out_if.sv]
interface cfir_out_if import cfir_pkg::*;;
    logic                         valid;
    logic                         ready;
    logic signed [OUT_BITS-1:0]   out_i;
    logic signed [OUT_BITS-1:0]   out_q;

    modport source (output valid, out_i, out_q, input ready);
    modport sink (input valid, out_i, out_q, output ready);
endinterface

[sv/cfir_cell.sv]
module cfir_cell import cfir_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  t_cell_ctl        i_ctl,
    input  t_smp             i_head,
    input  t_smp             i_next,
    output t_smp             o_smp
);

    t_smp r_smp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp <= '0;
        end else if (i_ctl.clear) begin
            r_smp <= '0;
        end else if (i_ctl.write && (i_index == i_ctl.wr_pos)) begin
            r_smp <= i_ctl.smp;
        end else if (i_ctl.shift && (i_index <= i_ctl.last)) begin
            // last active cell closes the ring back to the head
            r_smp <= (i_index == i_ctl.last) ? i_head : i_next;
        end
    end

    assign o_smp = r_smp;

endmodule

[sv/cfir_mac.sv]
module cfir_mac import cfir_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_mac_ctl                   i_ctl,
    input  t_smp                       i_smp,
    output logic                       o_busy,
    output logic signed [OUT_BITS-1:0] o_acc_i,
    output logic signed [OUT_BITS-1:0] o_acc_q
);

    logic signed [SAMPLE_BITS-1:0] r_coef_mem [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] r_coef;
    t_smp                          r_smp;
    logic signed [PROD_BITS-1:0]   r_prod_i;
    logic signed [PROD_BITS-1:0]   r_prod_q;
    logic signed [OUT_BITS-1:0]    r_acc_i;
    logic signed [OUT_BITS-1:0]    r_acc_q;
    logic                          r_v1;
    logic                          r_v2;

    always_ff @(posedge i_clk) begin
        if (i_ctl.coef_we) begin
            r_coef_mem[i_ctl.coef_wa] <= i_ctl.coef_wd;
        end
        if (i_ctl.issue) begin
            r_coef <= r_coef_mem[i_ctl.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_smp <= i_smp;
        end
        if (r_v1) begin
            r_prod_i <= r_coef * r_smp.i;
            r_prod_q <= r_coef * r_smp.q;
        end
        if (i_ctl.clr_acc) begin
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (r_v2) begin
            // wrap to output width
            r_acc_i <= r_acc_i + OUT_BITS'(r_prod_i);
            r_acc_q <= r_acc_q + OUT_BITS'(r_prod_q);
        end
    end

    assign o_busy  = r_v1 | r_v2;
    assign o_acc_i = r_acc_i;
    assign o_acc_q = r_acc_q;

endmodule

[sv/complex_fir_filter_top.sv]
// Complex-sample, real-coefficient FIR. A push transaction writes the I/Q sample into a
// ring of history cells at the write position and then rotates the active part of the
// ring once around, multiplying the cell at the head by one coefficient per cycle from
// the coefficient RAM and accumulating a 40-bit Q9.30 sum for I and Q. The result is
// loaded into the output register once the multiply-accumulate pipeline has drained and
// the output register is free; only then is the next transaction accepted, so the single
// multiply-accumulate lane walking the ring sets the pace of pushes. Coefficient writes
// and clears complete without leaving idle.
// The input is accepted whenever the sequencer is idle, even while a finished result still
// waits in the output register. Coefficients read as unknown until written. tap_count is
// taken as 1 when written as 0 and as 256 when written larger.
module complex_fir_filter_top import cfir_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [TAP_REG_BITS-1:0] i_cfg_wdata,
    cfir_in_if.sink                 i_in,
    cfir_out_if.source              o_out
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ROT   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [TAP_REG_BITS-1:0]    r_tap_count;
    logic [1:0]                 r_state, n_state;
    logic [CNT_W-1:0]           r_n, n_n;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic [IDX_W-1:0]           r_caddr, n_caddr;
    logic [IDX_W-1:0]           r_wpos, n_wpos;
    logic                       r_out_valid;
    logic signed [OUT_BITS-1:0] r_out_i;
    logic signed [OUT_BITS-1:0] r_out_q;

    logic [CNT_W-1:0]           w_n;
    logic [IDX_W-1:0]           w_pos_eff;
    logic [CNT_W-1:0]           w_pos_inc;
    logic                       w_in_acc;
    logic                       w_push;
    logic                       w_out_load;
    logic                       w_mac_busy;
    logic signed [OUT_BITS-1:0] w_acc_i;
    logic signed [OUT_BITS-1:0] w_acc_q;
    t_cell_ctl                  w_cell_ctl;
    t_mac_ctl                   w_mac_ctl;
    t_smp                       w_cell [MAX_TAPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_REG_BITS'(MAX_TAPS);
        end else if (i_cfg_we) begin
            r_tap_count <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_tap_count == '0) begin
            w_n = CNT_W'(1);
        end else if (32'(r_tap_count) > MAX_TAPS) begin
            w_n = CNT_W'(MAX_TAPS);
        end else begin
            w_n = CNT_W'(r_tap_count);
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid & i_in.ready;
    assign w_push     = w_in_acc && (i_in.operation == OP_PUSH);

    // wrap a stale write position after tap_count was lowered
    assign w_pos_eff  = (CNT_W'(r_wpos) >= w_n) ? '0 : r_wpos;
    assign w_pos_inc  = CNT_W'(w_pos_eff) + CNT_W'(1);

    assign w_out_load = (r_state == S_DRAIN) && !w_mac_busy
                        && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_cnt   = r_cnt;
        n_caddr = r_caddr;
        n_wpos  = r_wpos;
        unique case (r_state)
            S_IDLE: begin
                if (w_push) begin
                    n_state = S_ROT;
                    n_n     = w_n;
                    n_cnt   = w_n;
                    n_caddr = w_pos_eff;
                    n_wpos  = (w_pos_inc == w_n) ? '0 : w_pos_inc[IDX_W-1:0];
                end else if (w_in_acc && (i_in.operation == OP_CLEAR)) begin
                    n_wpos = '0;
                end
            end
            S_ROT: begin
                n_cnt   = r_cnt - CNT_W'(1);
                n_caddr = (r_caddr == '0) ? IDX_W'(r_n - CNT_W'(1)) : r_caddr - IDX_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= CNT_W'(MAX_TAPS);
            r_cnt   <= '0;
            r_caddr <= '0;
            r_wpos  <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_cnt   <= n_cnt;
            r_caddr <= n_caddr;
            r_wpos  <= n_wpos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_i <= w_acc_i;
            r_out_q <= w_acc_q;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.out_i = r_out_i;
    assign o_out.out_q = r_out_q;

    always_comb begin
        w_cell_ctl.shift  = (r_state == S_ROT);
        w_cell_ctl.clear  = w_in_acc && (i_in.operation == OP_CLEAR);
        w_cell_ctl.write  = w_push;
        w_cell_ctl.wr_pos = w_pos_eff;
        w_cell_ctl.last   = IDX_W'(r_n - CNT_W'(1));
        w_cell_ctl.smp.i  = i_in.sample_i;
        w_cell_ctl.smp.q  = i_in.sample_q;
    end

    always_comb begin
        w_mac_ctl.issue   = (r_state == S_ROT);
        w_mac_ctl.clr_acc = w_push;
        w_mac_ctl.rd_addr = r_caddr;
        w_mac_ctl.coef_we = w_in_acc && (i_in.operation == OP_COEF)
                            && (32'(i_in.coef_index) < MAX_TAPS);
        w_mac_ctl.coef_wa = IDX_W'(i_in.coef_index);
        w_mac_ctl.coef_wd = i_in.coef_value;
    end

    for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
        t_smp w_next;
        if (g < MAX_TAPS - 1) begin : g_mid
            assign w_next = w_cell[g+1];
        end else begin : g_end
            assign w_next = '0;
        end
        cfir_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_ctl   (w_cell_ctl),
            .i_head  (w_cell[0]),
            .i_next  (w_next),
            .o_smp   (w_cell[g])
        );
    end

    cfir_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_smp   (w_cell[0]),
        .o_busy  (w_mac_busy),
        .o_acc_i (w_acc_i),
        .o_acc_q (w_acc_q)
    );

`ifndef ASSERT_OFF
    a_rot_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT) |-> (r_cnt != '0 && CNT_W'(r_caddr) < r_n))
        else $error("ring walk out of bounds");

    a_push_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> (r_state == S_ROT))
        else $error("push did not start the ring walk");

    a_out_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DRAIN))
        else $error("result loaded outside drain");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_mac_busy)
        else $error("MAC pipeline busy while idle");
`endif

endmodule
